// ===== rtl/sls_pkg.sv =====
// Package with types and constants shared by the script loop sequencer modules.
package sls_pkg;

    localparam int CMD_DEPTH_DEF   = 32;
    localparam int MAX_NESTING_DEF = 8;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_STEP = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Command kinds.
    localparam logic [2:0] KIND_COLOR    = 3'd0;
    localparam logic [2:0] KIND_FADE     = 3'd1;
    localparam logic [2:0] KIND_RUN      = 3'd2;
    localparam logic [2:0] KIND_WAIT     = 3'd3;
    localparam logic [2:0] KIND_LOOP_ON  = 3'd4;
    localparam logic [2:0] KIND_LOOP_OFF = 3'd5;
    localparam logic [2:0] KIND_DELETE   = 3'd6;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  cmd_kind;
        logic [7:0]  loop_count;
        logic [15:0] duration;
        logic        parallel_fade;
        logic [47:0] payload;
    } t_in_item;

    typedef struct packed {
        logic        accepted;
        logic        led_valid;
        logic [1:0]  led_kind;
        logic [47:0] led_payload;
        logic [15:0] led_duration;
        logic        led_parallel;
        logic        idle;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the input transaction and read the store
        logic execute;   // apply the transaction and emit the result
    } t_dp_cmd;

endpackage

// ===== rtl/script_loop_sequencer_top.sv =====
// Script loop sequencer: a ring of light commands with nested counted loops.
// In each transaction the store entry at the execute index is first read into a
// register on capture, and the state update with the loop counter write-back
// follows on execute. A new transaction may start in the cycle its predecessor's
// result is shown, but not while the predecessor is still executing.
// o_strobe marks the result for one cycle; the receiver cannot stall it.
module script_loop_sequencer_top #(
    parameter int CMD_DEPTH   = sls_pkg::CMD_DEPTH_DEF,
    parameter int MAX_NESTING = sls_pkg::MAX_NESTING_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  sls_pkg::t_in_item  i_item,
    output logic               o_strobe,
    output sls_pkg::t_out_item o_result
);
    import sls_pkg::*;

    t_dp_cmd w_cmd;

    sls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (w_cmd)
    );

    sls_datapath #(
        .CMD_DEPTH   (CMD_DEPTH),
        .MAX_NESTING (MAX_NESTING)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_done   (o_strobe),
        .o_result (o_result)
    );
endmodule

// ===== rtl/sls_datapath.sv =====
// Datapath of the script loop sequencer: command store, indices, loop stack, wait counter.
module sls_datapath #(
    parameter int CMD_DEPTH   = sls_pkg::CMD_DEPTH_DEF,
    parameter int MAX_NESTING = sls_pkg::MAX_NESTING_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sls_pkg::t_dp_cmd  i_cmd,
    input  sls_pkg::t_in_item i_item,
    output logic              o_done,
    output sls_pkg::t_out_item o_result
);
    import sls_pkg::*;

    localparam int AW = $clog2(CMD_DEPTH);
    localparam int DW = $clog2(MAX_NESTING + 1);
    localparam int SW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

    // Command store, one memory per field group.
    logic [2:0]  mem_kind  [CMD_DEPTH];
    logic [47:0] mem_pay   [CMD_DEPTH];
    logic [16:0] mem_time  [CMD_DEPTH];
    logic [7:0]  mem_cnt   [CMD_DEPTH];
    logic [AW-1:0] mem_start [CMD_DEPTH];
    logic [DW-1:0] mem_depth [CMD_DEPTH];
    logic [AW-1:0] r_stack [MAX_NESTING];

    logic [AW-1:0] r_wr, r_rd, r_ex;
    logic          r_in_loop, r_clr;
    logic [15:0]   r_wait;
    logic [DW-1:0] r_nest;
    t_in_item      r_item;
    t_out_item     r_res;
    logic          r_done;

    // Registered read data of the entry at the execute index.
    logic [2:0]    r_q_kind;
    logic [47:0]   r_q_pay;
    logic [16:0]   r_q_time;
    logic [7:0]    r_q_cnt;
    logic [AW-1:0] r_q_start;
    logic [DW-1:0] r_q_depth;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
        return (i == AW'(CMD_DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

    logic [AW-1:0] stack_top;
    logic [SW-1:0] nest_idx, nest_m1_idx;
    logic [DW-1:0] nest_m1;
    assign nest_m1     = r_nest - DW'(1);
    assign nest_idx    = SW'(r_nest);
    assign nest_m1_idx = SW'(nest_m1);
    assign stack_top   = r_stack[nest_m1_idx];

    // Store read with a registered output; index follows the pending clear.
    logic [AW-1:0] rd_addr;
    assign rd_addr = r_clr ? '0 : r_ex;
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item    <= i_item;
            r_q_kind  <= mem_kind[rd_addr];
            r_q_pay   <= mem_pay[rd_addr];
            r_q_time  <= mem_time[rd_addr];
            r_q_cnt   <= mem_cnt[rd_addr];
            r_q_start <= mem_start[rd_addr];
            r_q_depth <= mem_depth[rd_addr];
        end
    end

    // Execute-phase decisions.
    logic full, add_ok, st_we, cnt_we;
    logic [7:0] cnt_wdata;
    logic [AW-1:0] ex_base, wr_base;
    logic [15:0]   wait_base;
    assign ex_base   = r_clr ? '0 : r_ex;
    assign wr_base   = r_clr ? '0 : r_wr;
    assign wait_base = r_clr ? '0 : r_wait;
    assign full      = (ring_next(r_wr) == r_rd);

    always_comb begin
        add_ok = 1'b0;
        case (r_item.cmd_kind)
            KIND_LOOP_ON:  add_ok = !full && (r_nest < DW'(MAX_NESTING));
            KIND_LOOP_OFF: add_ok = !full && (r_nest != '0);
            KIND_COLOR, KIND_FADE, KIND_RUN, KIND_WAIT: add_ok = !full;
            default:       add_ok = 1'b0;
        endcase
    end

    logic step_run;
    assign step_run = (wait_base == '0) && (ex_base != wr_base);
    assign st_we = i_cmd.execute && (r_item.opcode == OP_ADD) && !r_clr && add_ok;

    always_comb begin
        cnt_we    = 1'b0;
        cnt_wdata = r_q_cnt;
        if (i_cmd.execute && r_item.opcode == OP_STEP && step_run
            && r_q_kind == KIND_LOOP_OFF) begin
            if (r_q_cnt > 8'd1) begin
                cnt_we = 1'b1; cnt_wdata = r_q_cnt - 8'd1;
            end else if (r_q_cnt == 8'd1 && r_q_depth != '0) begin
                cnt_we = 1'b1; cnt_wdata = r_q_time[7:0];
            end
        end
    end

    // Store writes: a new entry on add, a counter write-back on step.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            mem_kind[r_wr]  <= r_item.cmd_kind;
            mem_pay[r_wr]   <= r_item.payload;
            mem_cnt[r_wr]   <= (r_item.cmd_kind == KIND_LOOP_OFF) ? r_item.loop_count : 8'd0;
            mem_start[r_wr] <= ring_next(stack_top);
            mem_depth[r_wr] <= nest_m1;
            mem_time[r_wr]  <= (r_item.cmd_kind == KIND_LOOP_OFF)
                ? {9'd0, r_item.loop_count} : {r_item.parallel_fade, r_item.duration};
        end
        if (cnt_we) begin
            mem_cnt[ex_base] <= cnt_wdata;
        end
        if (st_we && r_item.cmd_kind == KIND_LOOP_ON) begin
            r_stack[nest_idx] <= r_wr;
        end
    end

    // Control state and result.
    t_out_item n_res;
    logic [AW-1:0] n_wr, n_rd, n_ex;
    logic n_in_loop, n_clr;
    logic [15:0] n_wait;
    logic [DW-1:0] n_nest;

    always_comb begin
        n_res = '0;
        n_wr = r_wr; n_rd = r_rd; n_ex = r_ex;
        n_in_loop = r_in_loop; n_clr = r_clr; n_wait = r_wait; n_nest = r_nest;
        case (r_item.opcode)
            OP_ADD: begin
                if (!r_clr) begin
                    if (r_item.cmd_kind == KIND_DELETE) begin
                        n_clr = 1'b1; n_res.accepted = 1'b1;
                    end else if (add_ok) begin
                        n_res.accepted = 1'b1;
                        n_wr = ring_next(r_wr);
                        if (r_item.cmd_kind == KIND_LOOP_ON) n_nest = r_nest + DW'(1);
                        if (r_item.cmd_kind == KIND_LOOP_OFF) n_nest = nest_m1;
                    end
                end
            end
            OP_STEP: begin
                if (r_clr) begin
                    n_wr = '0; n_rd = '0; n_ex = '0; n_in_loop = 1'b0;
                    n_clr = 1'b0; n_wait = '0; n_nest = '0;
                end
                if (!step_run) begin
                    n_res.idle = 1'b1;
                end else begin
                    case (r_q_kind)
                        KIND_LOOP_ON: begin
                            n_ex = ring_next(ex_base); n_in_loop = 1'b1;
                        end
                        KIND_LOOP_OFF: begin
                            if (r_q_cnt != 8'd1) begin
                                n_ex = r_q_start;
                            end else if (r_q_depth == '0) begin
                                n_ex = ring_next(ex_base);
                                n_rd = ring_next(ex_base);
                                n_in_loop = 1'b0;
                            end else begin
                                n_ex = ring_next(ex_base);
                            end
                        end
                        KIND_COLOR, KIND_FADE, KIND_RUN, KIND_WAIT: begin
                            if (r_q_kind != KIND_WAIT) begin
                                n_res.led_valid    = 1'b1;
                                n_res.led_kind     = r_q_kind[1:0];
                                n_res.led_payload  = r_q_pay;
                                n_res.led_duration = r_q_time[15:0];
                                n_res.led_parallel = r_q_time[16];
                            end
                            if (r_q_kind == KIND_RUN || r_q_kind == KIND_WAIT
                                || (r_q_kind == KIND_FADE && !r_q_time[16]))
                                n_wait = r_q_time[15:0];
                            n_ex = ring_next(ex_base);
                            if (!n_in_loop) n_rd = ring_next(ex_base);
                        end
                        default: n_ex = ring_next(ex_base);
                    endcase
                end
            end
            OP_TICK: begin
                if (r_wait != '0) n_wait = r_wait - 16'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_ex <= '0; r_in_loop <= 1'b0;
            r_clr <= 1'b0; r_wait <= '0; r_nest <= '0; r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.execute;
            if (i_cmd.execute) begin
                r_wr <= n_wr; r_rd <= n_rd; r_ex <= n_ex; r_in_loop <= n_in_loop;
                r_clr <= n_clr; r_wait <= n_wait; r_nest <= n_nest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) r_res <= n_res;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef NO_ASSERTIONS
    a_nest_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nest <= DW'(MAX_NESTING)) else $error("nesting depth out of range");
    a_one_hot_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !(r_res.accepted && (r_res.idle || r_res.led_valid)))
        else $error("result mixes add and step fields");
    a_idle_no_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_res.idle |-> !r_res.led_valid) else $error("idle step emitted a command");
`endif
endmodule

// ===== rtl/sls_ctrl.sv =====
// Controller of the script loop sequencer: sequences capture and execute cycles.
module sls_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output sls_pkg::t_dp_cmd o_cmd
);
    import sls_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} t_state;
    t_state r_state;

    // One transaction: capture and read, execute, result shown.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_start) r_state <= S_EXEC;
                S_EXEC: r_state <= S_OUT;
                S_OUT:  r_state <= i_start ? S_EXEC : S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state == S_EXEC);
    assign o_cmd.capture = i_start && !o_busy;
    assign o_cmd.execute = (r_state == S_EXEC);

`ifndef NO_ASSERTIONS
    a_exec_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.execute) else $error("capture not followed by execute");
    a_no_back_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |=> !o_cmd.execute) else $error("execute repeated");
    a_exec_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.execute |-> $past(o_cmd.capture)) else $error("execute without capture");
`endif
endmodule
